@@ rtl/core/mfde_pkg.sv @@
`default_nettype none

package mfde_pkg;

   // Screen and sprite geometry
   localparam int DISPLAY_WIDTH    = 64;
   localparam int DISPLAY_HEIGHT   = 32;
   localparam int SPRITE_MAX_WIDTH = 32;

   localparam int GLYPH_H    = 5;
   localparam int GLYPH_STEP = 4;

   localparam int COL_W  = $clog2(DISPLAY_WIDTH);
   localparam int CCNT_W = $clog2(DISPLAY_WIDTH + 1);
   localparam int ROW_W  = $clog2(DISPLAY_HEIGHT);
   localparam int RCNT_W = $clog2(DISPLAY_HEIGHT + 1);

   localparam int SPRITE_USED = (SPRITE_MAX_WIDTH < 32) ? SPRITE_MAX_WIDTH : 32;
   localparam logic [31:0] SPRITE_MASK = 32'((64'd1 << SPRITE_USED) - 64'd1);

   // Command codes
   localparam logic [2:0] FUNC_CLEAR  = 3'd0;
   localparam logic [2:0] FUNC_READ   = 3'd1;
   localparam logic [2:0] FUNC_WRITE  = 3'd2;
   localparam logic [2:0] FUNC_FILL   = 3'd3;
   localparam logic [2:0] FUNC_GLYPH  = 3'd4;
   localparam logic [2:0] FUNC_SPRITE = 3'd5;

   typedef logic [DISPLAY_WIDTH-1:0] row_type;
   typedef logic signed [18:0]       coord_type;

   // Glyph row k as a mask with the left column in bit 0
   function automatic logic [31:0] glyph_pattern(input logic [7:0] code, input logic [2:0] k);
      logic [14:0] rows;
      logic [2:0]  p;
      case (code)
         "0":     rows = 15'b111_101_101_101_111;
         "1":     rows = 15'b010_110_010_010_111;
         "2":     rows = 15'b110_001_010_100_111;
         "3":     rows = 15'b110_001_010_001_110;
         "4":     rows = 15'b101_101_111_001_001;
         "5":     rows = 15'b111_100_110_001_110;
         "6":     rows = 15'b011_100_111_101_111;
         "7":     rows = 15'b111_001_010_010_010;
         "8":     rows = 15'b111_101_111_101_111;
         "9":     rows = 15'b111_101_111_001_110;
         "A":     rows = 15'b010_101_111_101_101;
         "C":     rows = 15'b011_100_100_100_011;
         "D":     rows = 15'b110_101_101_101_110;
         "E":     rows = 15'b111_100_110_100_111;
         "F":     rows = 15'b111_100_110_100_100;
         "G":     rows = 15'b011_100_101_101_011;
         "H":     rows = 15'b101_101_111_101_101;
         "I":     rows = 15'b111_010_010_010_111;
         "K":     rows = 15'b101_101_110_101_101;
         "L":     rows = 15'b100_100_100_100_111;
         "M":     rows = 15'b101_111_111_101_101;
         "N":     rows = 15'b101_111_111_111_101;
         "O":     rows = 15'b010_101_101_101_010;
         "P":     rows = 15'b110_101_110_100_100;
         "R":     rows = 15'b110_101_110_101_101;
         "S":     rows = 15'b011_100_010_001_110;
         "T":     rows = 15'b111_010_010_010_010;
         "U":     rows = 15'b101_101_101_101_111;
         "W":     rows = 15'b101_101_101_111_101;
         default: rows = '0;
      endcase
      case (k)
         3'd0:    p = rows[14:12];
         3'd1:    p = rows[11:9];
         3'd2:    p = rows[8:6];
         3'd3:    p = rows[5:3];
         3'd4:    p = rows[2:0];
         default: p = '0;
      endcase
      return {29'd0, p[0], p[1], p[2]};
   endfunction

   // Place a bit pattern so that its bit 0 lands on column off; drop what falls off screen
   function automatic row_type place_bits(input logic [31:0] pat, input coord_type off);
      logic [DISPLAY_WIDTH+31:0] ext;
      coord_type                 neg;
      row_type                   res;
      ext = {{DISPLAY_WIDTH{1'b0}}, pat};
      neg = -off;
      res = '0;
      if (off >= 0 && off < DISPLAY_WIDTH) begin
         res = row_type'(ext << off[COL_W-1:0]);
      end else if (off < 0 && off > -32) begin
         res = row_type'(ext >> neg[4:0]);
      end
      return res;
   endfunction

   // Clamp a row coordinate to 0..DISPLAY_HEIGHT
   function automatic logic [RCNT_W-1:0] clamp_row(input coord_type v);
      logic [RCNT_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > DISPLAY_HEIGHT) begin
         res = RCNT_W'(DISPLAY_HEIGHT);
      end else begin
         res = v[RCNT_W-1:0];
      end
      return res;
   endfunction

   // Clamp a column coordinate to 0..DISPLAY_WIDTH
   function automatic logic [CCNT_W-1:0] clamp_col(input coord_type v);
      logic [CCNT_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > DISPLAY_WIDTH) begin
         res = CCNT_W'(DISPLAY_WIDTH);
      end else begin
         res = v[CCNT_W-1:0];
      end
      return res;
   endfunction

   // Columns below n set
   function automatic row_type low_mask(input logic [CCNT_W-1:0] n);
      row_type r;
      r = '1;
      if (n < DISPLAY_WIDTH) begin
         r = r << n[COL_W-1:0];
         r = ~r;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mono_framebuffer_draw_engine.sv @@
`default_nettype none

// Channel   Ports                                   Handshake
// command   start, busy, req_func .. req_sprite_bits  taken when start high, busy low
// result    rsp_strobe, rsp_read_pixel               valid for one cycle, cannot stall
//
// A command keeps busy high while it reads each of its clipped rows from frame memory in
// turn, then while the last row is written back. The result strobes in the first cycle
// that busy is low, and the next command may be taken in that same cycle.
// Clear walks every row; a command with no rows on screen goes straight back to idle.
// Synchronous reset marks every row as off through per-row valid flags; no sweep.
// The receiver cannot stall, so results never back up.

module mono_framebuffer_draw_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   input  logic signed [15:0] req_rect_width,
   input  logic signed [15:0] req_rect_height,
   input  logic               req_pixel_value,
   input  logic [7:0]         req_char_code,
   input  logic [7:0]         req_char_index,
   input  logic [7:0]         req_sprite_row,
   input  logic [31:0]        req_sprite_bits,
   output logic               rsp_strobe,
   output logic               rsp_read_pixel
);

   import mfde_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [RCNT_W-1:0] rd_row_ff, rd_row_in;
   logic [RCNT_W-1:0] r1_ff, r1_in;
   logic [2:0]        func_ff, func_in;
   coord_type         y_ff, y_in;
   coord_type         gx_ff, gx_in;
   logic [7:0]        code_ff, code_in;
   row_type           mask_ff, mask_in;
   logic              val_ff, val_in;
   logic              result_ff, result_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ROW_W-1:0]  wb_row_ff, wb_row_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_pix_ff, rsp_pix_in;

   logic [DISPLAY_HEIGHT-1:0] row_valid_ff;
   row_type                   frame_mem [DISPLAY_HEIGHT];
   row_type                   rdata_ff;
   logic                      rvalid_ff;

   coord_type xv, yv, top_v, bot_v;
   row_type   acc_mask;
   logic      acc_val;

   logic      issue;
   row_type   old_row, wb_mask, new_row;
   coord_type k_full;
   logic      we, pix_now;

   assign xv = coord_type'(req_x_pos);
   assign yv = coord_type'(req_y_pos);

   // Decode the command into a row span, a column mask and a value; glyph masks are built per row at write-back
   always_comb begin
      top_v    = '0;
      bot_v    = '0;
      acc_mask = '0;
      acc_val  = 1'b1;
      case (req_func)
         FUNC_CLEAR: begin
            bot_v    = coord_type'(DISPLAY_HEIGHT);
            acc_mask = '1;
            acc_val  = req_pixel_value;
         end
         FUNC_READ: begin
            top_v    = yv;
            bot_v    = yv + coord_type'(1);
            acc_mask = place_bits(32'd1, xv);
            acc_val  = 1'b0;
         end
         FUNC_WRITE: begin
            top_v    = yv;
            bot_v    = yv + coord_type'(1);
            acc_mask = place_bits(32'd1, xv);
            acc_val  = req_pixel_value;
         end
         FUNC_FILL: begin
            if (req_rect_width > 0 && req_rect_height > 0) begin
               top_v    = yv;
               bot_v    = yv + coord_type'(req_rect_height);
               acc_mask = low_mask(clamp_col(xv + coord_type'(req_rect_width)))
                          & ~low_mask(clamp_col(xv));
            end
            acc_val = req_pixel_value;
         end
         FUNC_GLYPH: begin
            top_v = yv;
            bot_v = yv + coord_type'(GLYPH_H);
         end
         FUNC_SPRITE: begin
            top_v    = yv + coord_type'(req_sprite_row);
            bot_v    = top_v + coord_type'(1);
            acc_mask = place_bits(req_sprite_bits & SPRITE_MASK, xv);
         end
         default: begin
            top_v = '0;
         end
      endcase
   end

   // Write-back stage: merge the mask into the row just read, or for a read test the masked pixel
   always_comb begin
      old_row = rvalid_ff ? rdata_ff : '0;
      k_full  = coord_type'({1'b0, wb_row_ff}) - y_ff;
      if (func_ff == FUNC_GLYPH) begin
         wb_mask = place_bits(glyph_pattern(code_ff, k_full[2:0]), gx_ff);
      end else begin
         wb_mask = mask_ff;
      end
      new_row = (old_row & ~wb_mask) | (wb_mask & {DISPLAY_WIDTH{val_ff}});
      we      = wb_valid_ff && (func_ff != FUNC_READ);
      pix_now = wb_valid_ff && (func_ff == FUNC_READ) && (|(old_row & wb_mask));
   end

   assign issue = (state_ff == ST_RUN) && (rd_row_ff < r1_ff);

   // Sequencer: walk the row span, one memory read per cycle
   always_comb begin
      state_in      = state_ff;
      rd_row_in     = rd_row_ff;
      r1_in         = r1_ff;
      func_in       = func_ff;
      y_in          = y_ff;
      gx_in         = gx_ff;
      code_in       = code_ff;
      mask_in       = mask_ff;
      val_in        = val_ff;
      result_in     = result_ff;
      wb_valid_in   = issue;
      wb_row_in     = rd_row_ff[ROW_W-1:0];
      rsp_strobe_in = 1'b0;
      rsp_pix_in    = rsp_pix_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_RUN;
               rd_row_in = clamp_row(top_v);
               r1_in     = clamp_row(bot_v);
               func_in   = req_func;
               y_in      = yv;
               gx_in     = coord_type'(xv + coord_type'(coord_type'(req_char_index) * GLYPH_STEP));
               code_in   = req_char_code;
               mask_in   = acc_mask;
               val_in    = acc_val;
               result_in = 1'b0;
            end
         end
         ST_RUN: begin
            result_in = result_ff | pix_now;
            if (issue) begin
               rd_row_in = rd_row_ff + RCNT_W'(1);
            end else begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_pix_in    = result_ff | pix_now;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wb_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         row_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         wb_valid_ff   <= wb_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (we) begin
            row_valid_ff[wb_row_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_row_ff  <= rd_row_in;
      r1_ff      <= r1_in;
      func_ff    <= func_in;
      y_ff       <= y_in;
      gx_ff      <= gx_in;
      code_ff    <= code_in;
      mask_ff    <= mask_in;
      val_ff     <= val_in;
      result_ff  <= result_in;
      wb_row_ff  <= wb_row_in;
      rsp_pix_ff <= rsp_pix_in;
   end

   // Frame memory: one read and one write port, read data registered
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff  <= frame_mem[rd_row_ff[ROW_W-1:0]];
         rvalid_ff <= row_valid_ff[rd_row_ff[ROW_W-1:0]];
      end
      if (we) begin
         frame_mem[wb_row_ff] <= new_row;
      end
   end

   assign busy           = (state_ff == ST_RUN);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_pixel = rsp_pix_ff;

endmodule

`default_nettype wire

@@ rtl/core/mfde_checker.sv @@
`default_nettype none

module mfde_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // A result only shows once the command has finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // A taken command keeps the engine busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command taken but engine not busy");

   // Every result follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a command");

   // Finishing a command always delivers its item
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("command finished without result");

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_checker (.*);

`default_nettype wire

@@ tb/mono_framebuffer_draw_engine_test.sv @@
`default_nettype none

module mono_framebuffer_draw_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mfde_pkg::*;

   // Command codes the block treats as no-ops
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = DISPLAY_HEIGHT + 8;
   localparam int SPRITE_COLS   = (SPRITE_MAX_WIDTH < 32) ? SPRITE_MAX_WIDTH : 32;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] rect_width;
      logic signed [15:0] rect_height;
      logic               value;
      logic [7:0]         char_code;
      logic [7:0]         char_index;
      logic [7:0]         sprite_row;
      logic [31:0]        sprite_bits;
   } draw_cmd_type;

   typedef struct packed {
      draw_cmd_type cmd;
      logic         fixed;
      logic         fixed_pixel;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_func = '0;
   logic signed [15:0] req_x_pos = '0;
   logic signed [15:0] req_y_pos = '0;
   logic signed [15:0] req_rect_width = '0;
   logic signed [15:0] req_rect_height = '0;
   logic               req_pixel_value = 1'b0;
   logic [7:0]         req_char_code = '0;
   logic [7:0]         req_char_index = '0;
   logic [7:0]         req_sprite_row = '0;
   logic [31:0]        req_sprite_bits = '0;
   logic               rsp_strobe;
   logic               rsp_read_pixel;

   logic [DISPLAY_WIDTH-1:0] frame_model [DISPLAY_HEIGHT];
   logic                     pending_read_pixel [$];
   plan_row_type             directed_plan [DIRECTED_ROWS];
   string                    glyph_codes = "ACDEFGHIKLMNOPRSTUW0123456789";
   int                       mismatches = 0;
   int                       cycle_count = 0;

   mono_framebuffer_draw_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_pixel_value (req_pixel_value),
      .req_char_code   (req_char_code),
      .req_char_index  (req_char_index),
      .req_sprite_row  (req_sprite_row),
      .req_sprite_bits (req_sprite_bits),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_pixel  (rsp_read_pixel)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Glyph rows top to bottom, three bits each, bit 2 the left column
   function automatic logic [14:0] glyph_shape(input logic [7:0] code);
      case (code)
         "A":     return {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
         "C":     return {3'd3, 3'd4, 3'd4, 3'd4, 3'd3};
         "D":     return {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
         "E":     return {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
         "F":     return {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
         "G":     return {3'd3, 3'd4, 3'd5, 3'd5, 3'd3};
         "H":     return {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
         "I":     return {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
         "K":     return {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
         "L":     return {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
         "M":     return {3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
         "N":     return {3'd5, 3'd7, 3'd7, 3'd7, 3'd5};
         "O":     return {3'd2, 3'd5, 3'd5, 3'd5, 3'd2};
         "P":     return {3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
         "R":     return {3'd6, 3'd5, 3'd6, 3'd5, 3'd5};
         "S":     return {3'd3, 3'd4, 3'd2, 3'd1, 3'd6};
         "T":     return {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
         "U":     return {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
         "W":     return {3'd5, 3'd5, 3'd5, 3'd7, 3'd5};
         "0":     return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
         "1":     return {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
         "2":     return {3'd6, 3'd1, 3'd2, 3'd4, 3'd7};
         "3":     return {3'd6, 3'd1, 3'd2, 3'd1, 3'd6};
         "4":     return {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
         "5":     return {3'd7, 3'd4, 3'd6, 3'd1, 3'd6};
         "6":     return {3'd3, 3'd4, 3'd7, 3'd5, 3'd7};
         "7":     return {3'd7, 3'd1, 3'd2, 3'd2, 3'd2};
         "8":     return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
         "9":     return {3'd7, 3'd5, 3'd7, 3'd1, 3'd6};
         default: return '0;
      endcase
   endfunction

   function automatic void set_model_pixel(input int x, input int y, input logic v);
      if (x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT) begin
         frame_model[y][x] = v;
      end
   endfunction

   function automatic int clamp_to(input int v, input int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   // Apply one command to the frame copy and return the pixel it reads
   function automatic logic draw_on_model(input draw_cmd_type c);
      int   x, y, w, h, idx, srow, x0, y0, x1, y1, gx, r, cc;
      logic [14:0] shape;
      logic rd;
      x    = $signed(c.x_pos);
      y    = $signed(c.y_pos);
      w    = $signed(c.rect_width);
      h    = $signed(c.rect_height);
      idx  = c.char_index;
      srow = c.sprite_row;
      rd   = 1'b0;
      case (c.func)
         FUNC_CLEAR: begin
            for (r = 0; r < DISPLAY_HEIGHT; r++) frame_model[r] = {DISPLAY_WIDTH{c.value}};
         end
         FUNC_READ: begin
            if (x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT) begin
               rd = frame_model[y][x];
            end
         end
         FUNC_WRITE: begin
            set_model_pixel(x, y, c.value);
         end
         FUNC_FILL: begin
            if (w > 0 && h > 0) begin
               x0 = clamp_to(x, DISPLAY_WIDTH);
               y0 = clamp_to(y, DISPLAY_HEIGHT);
               x1 = clamp_to(x + w, DISPLAY_WIDTH);
               y1 = clamp_to(y + h, DISPLAY_HEIGHT);
               for (r = y0; r < y1; r++)
                  for (cc = x0; cc < x1; cc++) set_model_pixel(cc, r, c.value);
            end
         end
         FUNC_GLYPH: begin
            shape = glyph_shape(c.char_code);
            gx    = x + idx * GLYPH_STEP;
            for (r = 0; r < GLYPH_H; r++)
               for (cc = 0; cc < 3; cc++)
                  if (shape[14 - 3 * r - cc]) set_model_pixel(gx + cc, y + r, 1'b1);
         end
         FUNC_SPRITE: begin
            for (cc = 0; cc < SPRITE_COLS; cc++)
               if (c.sprite_bits[cc]) set_model_pixel(x + cc, y + srow, 1'b1);
         end
         default: ;
      endcase
      return rd;
   endfunction

   function automatic plan_row_type plan(input logic [2:0] f, input int x, input int y,
                                         input int w, input int h, input logic v,
                                         input int code, input int idx, input int srow,
                                         input logic [31:0] bits, input logic fixed,
                                         input logic fixed_pixel);
      plan_row_type p;
      p.cmd.func        = f;
      p.cmd.x_pos       = 16'(x);
      p.cmd.y_pos       = 16'(y);
      p.cmd.rect_width  = 16'(w);
      p.cmd.rect_height = 16'(h);
      p.cmd.value       = v;
      p.cmd.char_code   = 8'(code);
      p.cmd.char_index  = 8'(idx);
      p.cmd.sprite_row  = 8'(srow);
      p.cmd.sprite_bits = bits;
      p.fixed           = fixed;
      p.fixed_pixel     = fixed_pixel;
      return p;
   endfunction

   // Mostly near the screen, now and then anywhere in the 16-bit range
   function automatic logic [15:0] coord_near(input int lo, input int hi);
      int t;
      if ($urandom_range(0, 99) < 8) return 16'($urandom);
      t = lo + int'($urandom_range(0, hi - lo));
      return 16'(t);
   endfunction

   function automatic logic [15:0] size_near(input int hi);
      int t;
      if ($urandom_range(0, 99) < 10) return 16'($urandom);
      t = int'($urandom_range(0, hi + 4)) - 4;
      return 16'(t);
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int           roll;
      // randomise every field, then shape the ones this command uses
      c.func        = 3'($urandom);
      c.x_pos       = 16'($urandom);
      c.y_pos       = 16'($urandom);
      c.rect_width  = 16'($urandom);
      c.rect_height = 16'($urandom);
      c.value       = 1'($urandom);
      c.char_code   = 8'($urandom);
      c.char_index  = 8'($urandom);
      c.sprite_row  = 8'($urandom);
      c.sprite_bits = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         c.func = FUNC_CLEAR;
      end else if (roll < 42) begin
         c.func  = FUNC_READ;
         c.x_pos = coord_near(-4, DISPLAY_WIDTH + 3);
         c.y_pos = coord_near(-4, DISPLAY_HEIGHT + 3);
      end else if (roll < 56) begin
         c.func  = FUNC_WRITE;
         c.x_pos = coord_near(-4, DISPLAY_WIDTH + 3);
         c.y_pos = coord_near(-4, DISPLAY_HEIGHT + 3);
      end else if (roll < 66) begin
         c.func        = FUNC_FILL;
         c.x_pos       = coord_near(-10, DISPLAY_WIDTH + 4);
         c.y_pos       = coord_near(-8, DISPLAY_HEIGHT + 4);
         c.rect_width  = size_near(24);
         c.rect_height = size_near(12);
      end else if (roll < 80) begin
         c.func  = FUNC_GLYPH;
         c.y_pos = coord_near(-4, DISPLAY_HEIGHT);
         if ($urandom_range(0, 9) == 0) begin
            // large index pulled back on screen by a negative x
            c.x_pos = 16'(int'($urandom_range(0, 70)) - 6 - GLYPH_STEP * int'(c.char_index));
         end else begin
            c.char_index = 8'($urandom_range(0, 15));
            c.x_pos      = coord_near(-6, 8);
         end
         if ($urandom_range(0, 9) < 7) begin
            c.char_code = glyph_codes[$urandom_range(0, glyph_codes.len() - 1)];
         end
      end else if (roll < 95) begin
         c.func  = FUNC_SPRITE;
         c.x_pos = coord_near(-34, DISPLAY_WIDTH);
         if ($urandom_range(0, 9) == 0) begin
            c.y_pos = 16'(int'($urandom_range(0, 40)) - 6 - int'(c.sprite_row));
         end else begin
            c.sprite_row = 8'($urandom_range(0, 7));
            c.y_pos      = coord_near(-8, DISPLAY_HEIGHT);
         end
         if ($urandom_range(0, 3) == 0) c.sprite_bits = $urandom & $urandom & $urandom;
      end else begin
         c.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end
      return c;
   endfunction

   // Mostly back to back or short gaps; every third stretch runs with none at all
   function automatic int idle_gap(input int n);
      int roll;
      if ((n / 150) % 3 == 2) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stimulus: directed table first, then random commands
   initial begin
      plan_row_type step;
      logic         model_pixel;
      int           n, gap;
      for (n = 0; n < DISPLAY_HEIGHT; n++) frame_model[n] = '0;

      // after reset the screen is dark
      directed_plan[0]  = plan(FUNC_READ,   0,  0, 0, 0, 1'b0, 0, 0, 0, '0, 1'b1, 1'b0);
      directed_plan[1]  = plan(FUNC_READ,  63, 31, 0, 0, 1'b1, 0, 0, 0, '0, 1'b1, 1'b0);
      // corner pixels
      directed_plan[2]  = plan(FUNC_WRITE,  0,  0, 0, 0, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[3]  = plan(FUNC_READ,   0,  0, 0, 0, 1'b0, 0, 0, 0, '0, 1'b1, 1'b1);
      directed_plan[4]  = plan(FUNC_WRITE, 63, 31, 0, 0, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[5]  = plan(FUNC_READ,  63, 31, 0, 0, 1'b0, 0, 0, 0, '0, 1'b1, 1'b1);
      // off-screen writes are dropped, off-screen reads give 0
      directed_plan[6]  = plan(FUNC_WRITE, -1,  0, 0, 0, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[7]  = plan(FUNC_READ,  -1,  0, 0, 0, 1'b1, 0, 0, 0, '0, 1'b1, 1'b0);
      directed_plan[8]  = plan(FUNC_READ,  64, 31, 0, 0, 1'b1, 0, 0, 0, '0, 1'b1, 1'b0);
      directed_plan[9]  = plan(FUNC_READ, -32768, 32767, -1, -1, 1'b1, 255, 255, 255,
                               32'hFFFF_FFFF, 1'b1, 1'b0);
      directed_plan[10] = plan(FUNC_WRITE, 32767, -32768, 0, 0, 1'b1, 0, 0, 0, '0,
                               1'b0, 1'b0);
      // rectangles: clipped, empty width, negative height, far off screen
      directed_plan[11] = plan(FUNC_FILL,  -5, -3, 10, 10, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[12] = plan(FUNC_FILL,   2,  2,  0,  5, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[13] = plan(FUNC_FILL,   2,  2,  5, -32768, 1'b1, 0, 0, 0, '0,
                               1'b0, 1'b0);
      directed_plan[14] = plan(FUNC_FILL, -32768, -32768, 32767, 32767, 1'b1, 0, 0, 0,
                               '0, 1'b0, 1'b0);
      directed_plan[15] = plan(FUNC_FILL, 32767, 32767, 32767, 32767, 1'b1, 0, 0, 0,
                               '0, 1'b0, 1'b0);
      // glyphs: plain, largest index, blank code, clipped at the corner
      directed_plan[16] = plan(FUNC_GLYPH,  4, 10, 0, 0, 1'b0, "A",   0, 0, '0, 1'b0, 1'b0);
      directed_plan[17] = plan(FUNC_GLYPH, -1000, 20, 0, 0, 1'b0, "9", 255, 0, '0,
                               1'b0, 1'b0);
      directed_plan[18] = plan(FUNC_GLYPH, 30,  0, 0, 0, 1'b0, "B",   0, 0, '0, 1'b0, 1'b0);
      directed_plan[19] = plan(FUNC_GLYPH, 62, 29, 0, 0, 1'b0, "W",   0, 0, '0, 1'b0, 1'b0);
      // full sprite mask running off the right edge, largest row offset
      directed_plan[20] = plan(FUNC_SPRITE, 40, -250, 0, 0, 1'b0, 0, 0, 255,
                               32'hFFFF_FFFF, 1'b0, 1'b0);
      // unused codes do nothing and read 0
      directed_plan[21] = plan(FUNC_SPARE_6, 0, 0, 8, 8, 1'b1, "A", 0, 0, 32'hFFFF_FFFF,
                               1'b1, 1'b0);
      directed_plan[22] = plan(FUNC_SPARE_7, 5, 5, 8, 8, 1'b1, "0", 0, 0, 32'hFFFF_FFFF,
                               1'b1, 1'b0);
      // clear to on, then read a pixel back as on
      directed_plan[23] = plan(FUNC_CLEAR,  0,  0, 0, 0, 1'b1, 0, 0, 0, '0, 1'b0, 1'b0);
      directed_plan[24] = plan(FUNC_READ,  17,  9, 0, 0, 1'b0, 0, 0, 0, '0, 1'b1, 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS + RANDOM_ITEMS; n++) begin
         if (n < DIRECTED_ROWS) begin
            step = directed_plan[n];
         end else begin
            step.cmd   = random_cmd();
            step.fixed = 1'b0;
            step.fixed_pixel = 1'b0;
         end
         // present the item and hold it until taken
         req_func        <= step.cmd.func;
         req_x_pos       <= step.cmd.x_pos;
         req_y_pos       <= step.cmd.y_pos;
         req_rect_width  <= step.cmd.rect_width;
         req_rect_height <= step.cmd.rect_height;
         req_pixel_value <= step.cmd.value;
         req_char_code   <= step.cmd.char_code;
         req_char_index  <= step.cmd.char_index;
         req_sprite_row  <= step.cmd.sprite_row;
         req_sprite_bits <= step.cmd.sprite_bits;
         start           <= 1'b1;
         do @(posedge clock); while (busy !== 1'b0);

         model_pixel = draw_on_model(step.cmd);
         pending_read_pixel.push_back(step.fixed ? step.fixed_pixel : model_pixel);

         gap = idle_gap(n);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;

      // drain, then watch for stray strobes
      while (pending_read_pixel.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS mono_framebuffer_draw_engine");
      end else begin
         $display("FAIL mono_framebuffer_draw_engine");
      end
      $finish;
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_read_pixel.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result item, read_pixel %b", $time, rsp_read_pixel);
         end else begin
            want = pending_read_pixel.pop_front();
            if (rsp_read_pixel !== want) begin
               mismatches++;
               $display("%0t: read_pixel expected %b, got %b", $time, want,
                        rsp_read_pixel);
            end
         end
      end
   end

   // Give up if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result items outstanding", $time,
                  pending_read_pixel.size());
         $display("FAIL mono_framebuffer_draw_engine");
         $finish;
      end
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/mfde_pkg.sv
rtl/core/mono_framebuffer_draw_engine.sv
rtl/core/mfde_checker.sv
tb/mono_framebuffer_draw_engine_test.sv
